// ----- hdl/utf8d_pkg.sv -----
// Shared types, constants and lead-byte decode for the UTF-8 stream decoder.
package utf8d_pkg;

  localparam int unsigned CpWidth = 31;
  localparam int unsigned PendWidth = 3;

  localparam logic [CpWidth-1:0] ReplChar = 31'd63;

  // One decoded result as held in the output queue
  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               is_repl;
    logic               last;
  } result_t;

  // Outcome of decoding a byte with no sequence open
  typedef struct packed {
    logic                 emit;
    logic [CpWidth-1:0]   code_point;
    logic                 is_repl;
    logic                 set_skip;
    logic [PendWidth-1:0] pending;
    logic [CpWidth-1:0]   partial;
  } fresh_t;

  // Classify a byte that starts fresh: ASCII, stray continuation or lead byte
  function automatic fresh_t fresh_decode(input logic [7:0] b);
    fresh_t f;
    f = '0;
    if (!b[7]) begin
      f.emit       = 1'b1;
      f.code_point = {23'd0, b};
    end else if (!b[6]) begin
      f.emit       = 1'b1;
      f.code_point = ReplChar;
      f.is_repl    = 1'b1;
      f.set_skip   = 1'b1;
    end else if (!b[5]) begin
      f.pending = 3'd1;
      f.partial = {26'd0, b[4:0]};
    end else if (!b[4]) begin
      f.pending = 3'd2;
      f.partial = {27'd0, b[3:0]};
    end else if (!b[3]) begin
      f.pending = 3'd3;
      f.partial = {28'd0, b[2:0]};
    end else if (!b[2]) begin
      f.pending = 3'd4;
      f.partial = {29'd0, b[1:0]};
    end else begin
      // 0xFC..0xFF all open six-byte sequences
      f.pending = 3'd5;
      f.partial = {30'd0, b[0]};
    end
    return f;
  endfunction

endpackage

// ----- hdl/utf8_stream_decoder_unit.sv -----
// Streaming decoder for legacy one-to-six-byte UTF-8, one byte beat in, code points out.
// A result is written into the result queue when its byte beat is accepted; the output shows the queue head.
// Throughput: one byte per cycle while results are taken; a byte that gives two
// results leaves at least two results queued and input ready drops until the queue holds at most one.
// Ready is high whenever the result queue holds at most one result.
// Reset (rst_ni low, asynchronous): no sequence open, not skipping, queue empty.
module utf8_stream_decoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [utf8d_pkg::CpWidth-1:0] code_point_o,
  output logic                          is_replacement_o,
  output logic                          last_of_run_o
);
  import utf8d_pkg::*;

  localparam logic [1:0] QDepth = 2'd3;

  // Decoder state
  logic [PendWidth-1:0] pend_q, pend_d;
  logic [CpWidth-1:0]   partial_q, partial_d;
  logic                 skip_q, skip_d;

  // Result queue
  result_t    queue_q [3];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  logic       in_acc, out_acc, is_cont;
  logic [1:0] res_cnt;
  result_t    res0, res1;
  fresh_t     fr;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign in_ready_o  = (count_q <= 2'd1);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != 2'd0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign is_cont     = (data_byte_i[7:6] == 2'b10);
  assign fr          = fresh_decode(data_byte_i);

  // Per-byte decode: up to two results and the next decoder state
  always_comb begin
    pend_d    = pend_q;
    partial_d = partial_q;
    skip_d    = skip_q;
    res_cnt   = 2'd0;
    res0      = '0;
    res1      = '0;
    if (pend_q != '0) begin
      if (is_cont) begin
        partial_d = {partial_q[CpWidth-7:0], data_byte_i[5:0]};
        pend_d    = pend_q - 3'd1;
        if (pend_q == 3'd1) begin
          res0.code_point = {partial_q[CpWidth-7:0], data_byte_i[5:0]};
          res_cnt         = 2'd1;
          partial_d       = '0;
        end
      end else begin
        // missing continuation: replace, then decode this byte afresh
        res0.code_point = ReplChar;
        res0.is_repl    = 1'b1;
        pend_d          = fr.pending;
        partial_d       = fr.partial;
        if (fr.emit) begin
          res1.code_point = fr.code_point;
          res1.is_repl    = fr.is_repl;
          res_cnt         = 2'd2;
        end else begin
          res_cnt = 2'd1;
        end
      end
    end else if (skip_q && is_cont) begin
      // swallow continuation bytes after a stray one
      res_cnt = 2'd0;
    end else begin
      skip_d          = fr.set_skip;
      pend_d          = fr.pending;
      partial_d       = fr.partial;
      res0.code_point = fr.code_point;
      res0.is_repl    = fr.is_repl;
      res_cnt         = fr.emit ? 2'd1 : 2'd0;
    end
    res0.last = (res_cnt == 2'd1);
    res1.last = 1'b1;
  end

  // Queue pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (in_acc) begin
      if (res_cnt == 2'd1) begin
        wr_ptr_d = ptr_inc(wr_ptr_q);
      end else if (res_cnt == 2'd2) begin
        wr_ptr_d = ptr_inc(ptr_inc(wr_ptr_q));
      end
      count_d = count_q + res_cnt;
    end
    if (out_acc) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
      count_d  = count_d - 2'd1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      partial_q <= '0;
      skip_q    <= 1'b0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      count_q   <= '0;
    end else begin
      if (in_acc) begin
        pend_q    <= pend_d;
        partial_q <= partial_d;
        skip_q    <= skip_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue payload writes
  always_ff @(posedge clk_i) begin
    if (in_acc && (res_cnt != 2'd0)) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (in_acc && (res_cnt == 2'd2)) begin
      queue_q[ptr_inc(wr_ptr_q)] <= res1;
    end
  end

  assign code_point_o     = queue_q[rd_ptr_q].code_point;
  assign is_replacement_o = queue_q[rd_ptr_q].is_repl;
  assign last_of_run_o    = queue_q[rd_ptr_q].last;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QDepth)
    else $error("result queue overfilled");

  a_no_skip_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((pend_q != '0) && skip_q))
    else $error("skipping while a sequence is open");

  a_seq_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (pend_q == 3'd1) && is_cont) |=> (pend_q == '0))
    else $error("sequence not closed after last continuation");

  a_double_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (res_cnt == 2'd2)) |-> (res0.is_repl && (res0.code_point == ReplChar)))
    else $error("double result without leading replacement");

endmodule

// ----- dv/tb_utf8_stream_decoder_unit.sv -----
// Self-checking testbench for the UTF-8 stream decoder: random byte beats in, code points checked.
module tb_utf8_stream_decoder_unit;
  import utf8d_pkg::*;

  localparam int unsigned NumRandomBeats = 600;
  localparam int unsigned HoldCycles     = 300;
  localparam int unsigned QuietLimit     = 2000;
  localparam int unsigned TailCycles     = 20;

  typedef enum int unsigned {RxAlways, RxCoin, RxPattern, RxSparse} rx_mode_e;

  // Predicts decoded code points per accepted byte and checks results in order
  class utf8_cp_scoreboard;
    result_t            expected_cps[$];
    logic [2:0]         seq_left;
    logic [CpWidth-1:0] seq_value;
    logic               skip_stray;
    int unsigned        mismatches;

    function new();
      seq_left   = '0;
      seq_value  = '0;
      skip_stray = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return expected_cps.size();
    endfunction

    function void push_cp(logic [CpWidth-1:0] cp, logic repl);
      result_t r;
      r.code_point = cp;
      r.is_repl    = repl;
      r.last       = 1'b0;
      expected_cps.push_back(r);
    endfunction

    // Byte seen with no sequence open: ASCII, stray continuation or lead
    function void start_fresh(logic [7:0] b);
      casez (b)
        8'b0???????: push_cp({23'd0, b}, 1'b0);
        8'b10??????: begin
          push_cp(ReplChar, 1'b1);
          skip_stray = 1'b1;
        end
        8'b110?????: begin seq_left = 3'd1; seq_value = {26'd0, b[4:0]}; end
        8'b1110????: begin seq_left = 3'd2; seq_value = {27'd0, b[3:0]}; end
        8'b11110???: begin seq_left = 3'd3; seq_value = {28'd0, b[2:0]}; end
        8'b111110??: begin seq_left = 3'd4; seq_value = {29'd0, b[1:0]}; end
        // 0xFC..0xFF: six-byte lead, bit 0 ends up as bit 30
        default:     begin seq_left = 3'd5; seq_value = {30'd0, b[0]}; end
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned first;
      first = expected_cps.size();
      if (seq_left != 3'd0) begin
        if (b[7:6] == 2'b10) begin
          seq_value = {seq_value[CpWidth-7:0], b[5:0]};
          seq_left  = seq_left - 3'd1;
          if (seq_left == 3'd0) begin
            push_cp(seq_value, 1'b0);
            seq_value = '0;
          end
        end else begin
          // missing continuation: replace, then decode this byte afresh
          push_cp(ReplChar, 1'b1);
          seq_left  = '0;
          seq_value = '0;
          start_fresh(b);
        end
      end else if (skip_stray) begin
        if (b[7:6] != 2'b10) begin
          skip_stray = 1'b0;
          start_fresh(b);
        end
      end else begin
        start_fresh(b);
      end
      if (expected_cps.size() > first) expected_cps[expected_cps.size()-1].last = 1'b1;
    endfunction

    // Prints one line per mismatch (capped) and counts all of them
    task flag(string what);
      mismatches++;
      if (mismatches <= 100) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_result(logic [CpWidth-1:0] cp, logic repl, logic last);
      result_t exp_r;
      if (expected_cps.size() == 0) begin
        flag($sformatf("unexpected result cp=%0h repl=%0b last=%0b", cp, repl, last));
      end else begin
        exp_r = expected_cps.pop_front();
        if (cp !== exp_r.code_point)
          flag($sformatf("code_point %0h, expected %0h", cp, exp_r.code_point));
        if (repl !== exp_r.is_repl)
          flag($sformatf("is_replacement %0b, expected %0b", repl, exp_r.is_repl));
        if (last !== exp_r.last)
          flag($sformatf("last_of_run %0b, expected %0b", last, exp_r.last));
      end
    endtask

    task close_out();
      if (expected_cps.size() != 0)
        flag($sformatf("%0d results never arrived", expected_cps.size()));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [7:0]         data_byte = 8'h00;
  logic               out_ready = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [CpWidth-1:0] code_point_o;
  logic               is_replacement_o;
  logic               last_of_run_o;

  utf8_cp_scoreboard sb = new();
  int unsigned       burst_left = 0;
  int unsigned       beats_sent = 0;
  logic              hold_req = 1'b0;

  utf8_stream_decoder_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .code_point_o     (code_point_o),
    .is_replacement_o (is_replacement_o),
    .last_of_run_o    (last_of_run_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Monitor: note accepted bytes first, then check any result beat
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) sb.note_byte(data_byte);
      if (out_valid_o && out_ready)
        sb.check_result(code_point_o, is_replacement_o, last_of_run_o);
    end
  end

  // Watchdog on cycles with no beat moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // Receiver: stall modes of random length, plus a long hold-off on request
  initial begin
    rx_mode_e    mode;
    int unsigned left;
    logic [7:0]  pat;
    mode = RxAlways;
    left = 0;
    pat  = 8'hFF;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          left = $urandom_range(16, 80);
          pat  = 8'($urandom);
        end
        left--;
        case (mode)
          RxAlways:  out_ready <= 1'b1;
          RxCoin:    out_ready <= 1'($urandom_range(0, 1));
          RxPattern: begin
            out_ready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one byte beat; opens a new burst after a random gap when needed
  task automatic offer_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    beats_sent++;
  endtask

  // Sender goes quiet until every predicted result has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (sb.outstanding() != 0);
    burst_left = 0;
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  function automatic logic [7:0] lead_byte(int unsigned len);
    case (len)
      2:       return {3'b110, 5'($urandom)};
      3:       return {4'b1110, 4'($urandom)};
      4:       return {5'b11110, 3'($urandom)};
      5:       return {6'b111110, 2'($urandom)};
      default: return {6'b111111, 2'($urandom)};
    endcase
  endfunction

  // Mostly well-formed sequences; some truncated, stray runs and raw noise
  task automatic random_run();
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      offer_byte({1'b0, 7'($urandom)});
    end else if (kind < 70) begin
      len = $urandom_range(2, 6);
      offer_byte(lead_byte(len));
      repeat (len - 1) offer_byte(cont_byte());
    end else if (kind < 80) begin
      len = $urandom_range(2, 6);
      cut = $urandom_range(0, len - 2);
      offer_byte(lead_byte(len));
      repeat (cut) offer_byte(cont_byte());
    end else if (kind < 88) begin
      repeat ($urandom_range(1, 4)) offer_byte(cont_byte());
    end else begin
      offer_byte(8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] seed_q[$];
    logic       hold_done;
    logic       pause_done;
    int unsigned goal;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // zero and top ASCII, 2- and 3-byte chars, six-byte max value from 0xFF lead,
    // stray continuations then ASCII, missing continuation before ASCII,
    // five-byte lead cut off by a two-byte sequence
    seed_q = '{8'h00, 8'h7F,
               8'hC2, 8'hA9,
               8'hE2, 8'h82, 8'hAC,
               8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
               8'h80, 8'hBF, 8'h41,
               8'hC3, 8'h41,
               8'hF8, 8'hC3, 8'hA9};
    foreach (seed_q[i]) offer_byte(seed_q[i]);
    drain();

    goal = beats_sent + NumRandomBeats;
    while (beats_sent < goal) begin
      if (!hold_done && beats_sent >= goal - 400) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && beats_sent >= goal - 200) begin
        drain();
        pause_done = 1'b1;
      end
      random_run();
    end

    drain();
    repeat (TailCycles) @(negedge clk_i);
    sb.close_out();
    if (sb.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
